// File: rtl/core/grc_pkg.sv
`default_nettype none

package grc_pkg;

  // Default build parameters.
  localparam int GRID_SIDE_DEF = 64;
  localparam int MAX_RATIO_DEF = 6;

  // Stream and configuration widths.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  // Request codes.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TAKE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  // Datapath commands issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_LOAD_RD,
    OP_LOAD_WR,
    OP_MARKS,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_TAKE_INIT,
    OP_PROBE_SEED,
    OP_SCAN_STEP,
    OP_SEED_HIT,
    OP_GROW_W,
    OP_GROW_H,
    OP_GROW_WH,
    OP_PROBE_COL,
    OP_PROBE_ROW,
    OP_PROBE_CORNER,
    OP_IDX_CLR,
    OP_CLR_RD,
    OP_CLR_WR,
    OP_EMIT_HIT,
    OP_EMIT_MISS
  } op_t;

  // Status reported by the datapath.
  typedef struct packed {
    logic [1:0] req;
    logic       idx_last;
    logic       probe_free;
    logic       scan_last;
    logic       w_oob;
    logic       h_oob;
    logic       idx_lt_h;
    logic       idx_lt_w;
    logic       ratio_break;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/grc_ctrl.sv
`default_nettype none

module grc_ctrl
  import grc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output op_t          op
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_LOAD_WR,
    S_COPY_RD,
    S_COPY_WR,
    S_SCAN_RD,
    S_SCAN_EV,
    S_ROUND,
    S_COL_RD,
    S_COL_EV,
    S_ROW_START,
    S_ROW_RD,
    S_ROW_EV,
    S_CORNER,
    S_CORNER_EV,
    S_RATIO,
    S_CLR_START,
    S_CLR_RD,
    S_CLR_WR,
    S_EMIT_HIT,
    S_EMIT_MISS
  } state_t;

  state_t state, state_next;
  logic   widen, widen_next;
  logic   heighten, heighten_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    widen_next    = widen;
    heighten_next = heighten;
    op            = OP_NONE;
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (st.idx_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.req)
          REQ_LOAD: begin
            op         = OP_LOAD_RD;
            state_next = S_LOAD_WR;
          end
          REQ_START: begin
            op         = OP_MARKS;
            state_next = S_COPY_RD;
          end
          REQ_TAKE: begin
            op         = OP_TAKE_INIT;
            state_next = S_SCAN_RD;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LOAD_WR: begin
        op         = OP_LOAD_WR;
        state_next = S_IDLE;
      end
      S_COPY_RD: begin
        op         = OP_COPY_RD;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        op         = OP_COPY_WR;
        state_next = st.idx_last ? S_IDLE : S_COPY_RD;
      end
      S_SCAN_RD: begin
        op         = OP_PROBE_SEED;
        state_next = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (st.probe_free) begin
          op            = OP_SEED_HIT;
          widen_next    = 1'b1;
          heighten_next = 1'b1;
          state_next    = S_ROUND;
        end else if (st.scan_last) begin
          state_next = S_EMIT_MISS;
        end else begin
          op         = OP_SCAN_STEP;
          state_next = S_SCAN_RD;
        end
      end
      S_ROUND: begin
        if (widen && heighten) op = OP_GROW_WH;
        else if (widen) op = OP_GROW_W;
        else op = OP_GROW_H;
        widen_next    = widen && !st.w_oob;
        heighten_next = heighten && !st.h_oob;
        state_next    = (widen && !st.w_oob) ? S_COL_RD : S_ROW_START;
      end
      S_COL_RD: begin
        if (st.idx_lt_h) begin
          op         = OP_PROBE_COL;
          state_next = S_COL_EV;
        end else begin
          state_next = S_ROW_START;
        end
      end
      S_COL_EV: begin
        if (st.probe_free) begin
          state_next = S_COL_RD;
        end else begin
          widen_next = 1'b0;
          state_next = S_ROW_START;
        end
      end
      S_ROW_START: begin
        op         = OP_IDX_CLR;
        state_next = heighten ? S_ROW_RD : S_CORNER;
      end
      S_ROW_RD: begin
        if (st.idx_lt_w) begin
          op         = OP_PROBE_ROW;
          state_next = S_ROW_EV;
        end else begin
          state_next = S_CORNER;
        end
      end
      S_ROW_EV: begin
        if (st.probe_free) begin
          state_next = S_ROW_RD;
        end else begin
          heighten_next = 1'b0;
          state_next    = S_CORNER;
        end
      end
      S_CORNER: begin
        if (widen && heighten) begin
          op         = OP_PROBE_CORNER;
          state_next = S_CORNER_EV;
        end else begin
          state_next = S_RATIO;
        end
      end
      S_CORNER_EV: begin
        if (!st.probe_free) heighten_next = 1'b0;
        state_next = S_RATIO;
      end
      S_RATIO: begin
        if (st.ratio_break || !(widen || heighten)) state_next = S_CLR_START;
        else state_next = S_ROUND;
      end
      S_CLR_START: begin
        op         = OP_IDX_CLR;
        state_next = S_CLR_RD;
      end
      S_CLR_RD: begin
        if (st.idx_lt_h) begin
          op         = OP_CLR_RD;
          state_next = S_CLR_WR;
        end else begin
          state_next = S_EMIT_HIT;
        end
      end
      S_CLR_WR: begin
        op         = OP_CLR_WR;
        state_next = S_CLR_RD;
      end
      S_EMIT_HIT: begin
        if (st.out_free) begin
          op         = OP_EMIT_HIT;
          state_next = S_IDLE;
        end
      end
      S_EMIT_MISS: begin
        if (st.out_free) begin
          op         = OP_EMIT_MISS;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      widen    <= 1'b0;
      heighten <= 1'b0;
    end else begin
      state    <= state_next;
      widen    <= widen_next;
      heighten <= heighten_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/grc_datapath.sv
`default_nettype none

module grc_datapath
  import grc_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int MAX_RATIO = MAX_RATIO_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire op_t                   op,
  output status_t                    st,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic                       out_user,
  output logic [OUT_DATA_W-1:0]      out_data
);

  localparam int CW = $clog2(GRID_SIDE);
  localparam int DW = $clog2(GRID_SIDE + 1);
  localparam int AW = DW + 1;
  localparam int RW = DW + 7;

  // Configuration registers and the effective grid size.
  logic [CFG_DATA_W-1:0] grid_w_reg, grid_h_reg;
  logic [DW-1:0]         wd, ht;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w_reg <= CFG_DATA_W'(64);
      grid_h_reg <= CFG_DATA_W'(64);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_GRID_WIDTH) grid_w_reg <= cfg_data;
      if (cfg_index == CFG_GRID_HEIGHT) grid_h_reg <= cfg_data;
    end
  end

  always_comb begin
    if (grid_w_reg == '0) wd = DW'(1);
    else if (32'(grid_w_reg) > 32'(GRID_SIDE)) wd = DW'(GRID_SIDE);
    else wd = DW'(grid_w_reg);
    if (grid_h_reg == '0) ht = DW'(1);
    else if (32'(grid_h_reg) > 32'(GRID_SIDE)) ht = DW'(GRID_SIDE);
    else ht = DW'(grid_h_reg);
  end

  // Latched request.
  logic [1:0] req_q;
  logic [5:0] ld_x, ld_y;
  logic       ld_filled;
  logic [2:0] corner;

  always_ff @(posedge clk) begin
    if (op == OP_ACCEPT) begin
      req_q     <= in_data[1:0];
      ld_x      <= in_data[7:2];
      ld_y      <= in_data[13:8];
      ld_filled <= in_data[14];
      corner    <= in_data[17:15];
    end
  end

  // Corner decode: columns run leftward for corners two to five, rows run
  // upward for corners four to seven, even corners scan along rows.
  logic dx_pos, dy_pos, inner_x;
  assign dx_pos  = (corner[2:1] == 2'b00) || (corner[2:1] == 2'b11);
  assign dy_pos  = !corner[2];
  assign inner_x = !corner[0];

  // Working registers.
  logic [CW-1:0] cur_x, cur_y, sel;
  logic [DW-1:0] w, h, idx;
  logic [CW-1:0] mark_x [8];
  logic [CW-1:0] mark_y [8];

  logic [AW-1:0] xa, ya, wa, ha, ia, wda, hta;
  assign xa  = AW'(cur_x);
  assign ya  = AW'(cur_y);
  assign wa  = AW'(w);
  assign ha  = AW'(h);
  assign ia  = AW'(idx);
  assign wda = AW'(wd);
  assign hta = AW'(ht);

  // Scan path.
  logic          row_end, col_end;
  logic [CW-1:0] scan_x, scan_y;

  assign row_end = dx_pos ? (xa == wda - AW'(1)) : (cur_x == '0);
  assign col_end = dy_pos ? (ya == hta - AW'(1)) : (cur_y == '0);

  always_comb begin
    scan_x = cur_x;
    scan_y = cur_y;
    if (inner_x) begin
      if (row_end) begin
        scan_x = dx_pos ? '0 : CW'(wd - DW'(1));
        scan_y = dy_pos ? cur_y + CW'(1) : cur_y - CW'(1);
      end else begin
        scan_x = dx_pos ? cur_x + CW'(1) : cur_x - CW'(1);
      end
    end else begin
      if (col_end) begin
        scan_y = dy_pos ? '0 : CW'(ht - DW'(1));
        scan_x = dx_pos ? cur_x + CW'(1) : cur_x - CW'(1);
      end else begin
        scan_y = dy_pos ? cur_y + CW'(1) : cur_y - CW'(1);
      end
    end
  end

  // Growth geometry.
  logic [AW-1:0] far_x, far_y, idx_x, idx_y, rx, ry, clr_row;
  logic [AW-1:0] probe_x, probe_y;

  assign far_x   = dx_pos ? xa + wa : xa - wa;
  assign far_y   = dy_pos ? ya + ha : ya - ha;
  assign idx_x   = dx_pos ? xa + ia : xa - ia;
  assign idx_y   = dy_pos ? ya + ia : ya - ia;
  assign rx      = dx_pos ? xa : xa - wa + AW'(1);
  assign ry      = dy_pos ? ya : ya - ha + AW'(1);
  assign clr_row = ry + ia;

  always_comb begin
    case (op)
      OP_PROBE_COL: begin
        probe_x = far_x;
        probe_y = idx_y;
      end
      OP_PROBE_ROW: begin
        probe_x = idx_x;
        probe_y = far_y;
      end
      OP_PROBE_CORNER: begin
        probe_x = far_x;
        probe_y = far_y;
      end
      default: begin
        probe_x = xa;
        probe_y = ya;
      end
    endcase
  end

  // Cell maps, one grid row per word.
  logic [GRID_SIDE-1:0] filled_mem [GRID_SIDE];
  logic [GRID_SIDE-1:0] free_mem [GRID_SIDE];
  logic [GRID_SIDE-1:0] filled_q, free_q, ld_row, clr_mask;
  logic [CW-1:0]        filled_raddr, free_raddr, ld_cx, ld_cy;
  logic                 ld_in;

  assign ld_in = (32'(ld_x) < 32'(GRID_SIDE)) && (32'(ld_y) < 32'(GRID_SIDE));
  assign ld_cx = CW'(ld_x);
  assign ld_cy = CW'(ld_y);

  always_comb begin
    ld_row        = filled_q;
    ld_row[ld_cx] = ld_filled;
  end

  always_comb begin
    for (int b = 0; b < GRID_SIDE; b++) begin
      clr_mask[b] = (AW'(b) >= rx) && (AW'(b) < rx + wa);
    end
  end

  assign filled_raddr = (op == OP_LOAD_RD) ? ld_cy : idx[CW-1:0];
  assign free_raddr   = (op == OP_CLR_RD) ? clr_row[CW-1:0] : probe_y[CW-1:0];

  always_ff @(posedge clk) begin
    if (op == OP_CLEAR) filled_mem[idx[CW-1:0]] <= '0;
    else if (op == OP_LOAD_WR && ld_in) filled_mem[ld_cy] <= ld_row;
    filled_q <= filled_mem[filled_raddr];
  end

  always_ff @(posedge clk) begin
    if (op == OP_CLEAR) free_mem[idx[CW-1:0]] <= '0;
    else if (op == OP_COPY_WR) free_mem[idx[CW-1:0]] <= filled_q;
    else if (op == OP_CLR_WR) free_mem[clr_row[CW-1:0]] <= free_q & ~clr_mask;
    free_q <= free_mem[free_raddr];
  end

  // Counters, seed position and rectangle size.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      for (int c = 0; c < 8; c++) begin
        mark_x[c] <= '0;
        mark_y[c] <= '0;
      end
    end else begin
      case (op)
        OP_ACCEPT, OP_IDX_CLR, OP_SEED_HIT,
        OP_GROW_W, OP_GROW_H, OP_GROW_WH: idx <= '0;
        OP_CLEAR, OP_COPY_WR, OP_PROBE_COL,
        OP_PROBE_ROW, OP_CLR_WR: idx <= idx + DW'(1);
        default: idx <= idx;
      endcase
      if (op == OP_MARKS) begin
        for (int c = 0; c < 8; c++) begin
          mark_x[c] <= (c >= 2 && c <= 5) ? CW'(wd - DW'(1)) : '0;
          mark_y[c] <= (c >= 4) ? CW'(ht - DW'(1)) : '0;
        end
      end else if (op == OP_SEED_HIT) begin
        mark_x[corner] <= cur_x;
        mark_y[corner] <= cur_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_TAKE_INIT: begin
        cur_x <= (AW'(mark_x[corner]) >= wda) ? CW'(wd - DW'(1)) : mark_x[corner];
        cur_y <= (AW'(mark_y[corner]) >= hta) ? CW'(ht - DW'(1)) : mark_y[corner];
      end
      OP_SCAN_STEP: begin
        cur_x <= scan_x;
        cur_y <= scan_y;
      end
      OP_SEED_HIT: begin
        w <= '0;
        h <= '0;
      end
      OP_GROW_W: w <= w + DW'(1);
      OP_GROW_H: h <= h + DW'(1);
      OP_GROW_WH: begin
        w <= w + DW'(1);
        h <= h + DW'(1);
      end
      default: begin
      end
    endcase
    if (op == OP_PROBE_SEED || op == OP_PROBE_COL || op == OP_PROBE_ROW ||
        op == OP_PROBE_CORNER) begin
      sel <= probe_x[CW-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT_HIT || op == OP_EMIT_MISS) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT_HIT) begin
      out_user <= 1'b1;
      out_data <= {6'd0, 7'(h), 7'(w), 6'(ry), 6'(rx)};
    end else if (op == OP_EMIT_MISS) begin
      out_user <= 1'b0;
      out_data <= '0;
    end
  end

  // Status back to the controller. The bounds tests look one step ahead.
  always_comb begin
    st.req         = req_q;
    st.idx_last    = (idx == DW'(GRID_SIDE - 1));
    st.probe_free  = free_q[sel];
    st.scan_last   = row_end && col_end;
    st.w_oob       = dx_pos ? (xa + wa + AW'(1) >= wda) : (wa + AW'(1) > xa);
    st.h_oob       = dy_pos ? (ya + ha + AW'(1) >= hta) : (ha + AW'(1) > ya);
    st.idx_lt_h    = (idx < h);
    st.idx_lt_w    = (idx < w);
    st.ratio_break = (RW'(h) > RW'(MAX_RATIO) * RW'(w)) ||
                     (RW'(w) > RW'(MAX_RATIO) * RW'(h));
    st.out_free    = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// File: rtl/core/greedy_rectangle_cover.sv
// Greedy rectangle cover of a binary cell grid.
//
// Requests arrive as transfers on the s_axis channel. A load request writes
// one cell of the filled map, a start request copies the filled map into the
// free map and puts the eight scan marks at the grid corners, and a take
// request finds the next free cell from the chosen corner, grows a rectangle
// from it, clears it from the free map and returns it as one transfer on the
// m_axis channel. Only take requests produce a result.
// The grid size registers are written through the cfg channel, which is
// always ready; write them only while the block is idle.
// After reset both maps are cleared row by row, one row per cycle, and
// s_axis_tready stays low until the clear is done.
// Requests are handled one at a time by a controller stepping a row-wide
// map memory. A take scans cells from the corner's mark to a free one,
// grows the rectangle in rounds that probe the new column, row and corner,
// then clears the rectangle row by row, each probe and clear bounded by the
// one read port of the free map.
// The result sits in an output register; a stalled receiver only holds the
// block when the next result is ready to be written.

`default_nettype none

module greedy_rectangle_cover
  import grc_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int MAX_RATIO = MAX_RATIO_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0: req_type[1:0], cell_x[7:2], cell_y[13:8],
  // cell_filled[14], scan_corner[17:15], zero pad.
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // Fields from bit 0: rect_x[5:0], rect_y[11:6], rect_w[18:12],
  // rect_h[25:19], zero pad.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // Fields from bit 0: found[0].
  output logic                       m_axis_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  op_t     op;
  status_t st;

  // Configuration writes are never stalled.
  assign cfg_ready = 1'b1;

  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .op       (op)
  );

  grc_datapath #(
    .GRID_SIDE (GRID_SIDE),
    .MAX_RATIO (MAX_RATIO)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .st        (st),
    .in_data   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_user  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/grc_checker.sv
`default_nettype none

module grc_checker
  import grc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A miss carries an all-zero rectangle.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with nonzero rectangle");

  // A found rectangle always has at least one cell each way.
  a_hit_size: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[18:12] != 7'd0 &&
                                      m_axis_tdata[25:19] != 7'd0)
    else $error("found rectangle with zero size");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind greedy_rectangle_cover grc_checker u_grc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the greedy rectangle cover block.
// A queue of pending requests feeds a bursty stream driver. Every accepted
// request is applied to a bench-side copy of the cell maps and scan marks,
// and every take request pushes the rectangle it should return. The monitor
// pops those expectations in order and compares them field by field.

module testbench;
  import grc_pkg::*;

  localparam int SIDE      = GRID_SIDE_DEF;
  localparam int RATIO     = MAX_RATIO_DEF;
  localparam int ITEM_GOAL = 1900;

  // Request code that the block ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic       found;
    logic [5:0] x;
    logic [5:0] y;
    logic [6:0] w;
    logic [6:0] h;
  } rect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  greedy_rectangle_cover DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Bench copy of the block state. Maps are indexed [row][column].
  bit         filled_cells [SIDE][SIDE];
  bit         free_cells   [SIDE][SIDE];
  int         mark_col     [8];
  int         mark_row     [8];
  logic [6:0] width_reg  = 7'd64;
  logic [6:0] height_reg = 7'd64;

  logic [IN_DATA_W-1:0] pending_reqs [$];
  rect_t                expected_rects [$];
  int  items_queued  = 0;
  int  results_seen  = 0;
  bit  failed        = 1'b0;

  function automatic int used_dim(logic [6:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return int'(v);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_req(logic [1:0] kind, logic [5:0] cx,
                                                    logic [5:0] cy, logic fill,
                                                    logic [2:0] corner);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[1:0]   = kind;
    d[7:2]   = cx;
    d[13:8]  = cy;
    d[14]    = fill;
    d[17:15] = corner;
    return d;
  endfunction

  // Scan from the corner's mark to the first free cell, grow a rectangle from
  // it and clear it from the free map.
  function automatic rect_t take_rect(int c);
    rect_t r;
    int gw, gh, dx, dy, x, y, w, h, nx, ny, i, rx, ry, ix, iy;
    bit along_row, hit, widen, heighten;
    gw = used_dim(width_reg);
    gh = used_dim(height_reg);
    dx = (c >= 2 && c <= 5) ? -1 : 1;
    dy = (c >= 4) ? -1 : 1;
    along_row = (c % 2) == 0;
    x = mark_col[c];
    y = mark_row[c];
    hit = 1'b0;
    r = '0;
    // A mark left outside a grid that shrank is pulled back inside.
    if (x >= gw) x = gw - 1;
    if (y >= gh) y = gh - 1;
    while (x >= 0 && x < gw && y >= 0 && y < gh) begin
      if (free_cells[y][x]) begin
        hit = 1'b1;
        break;
      end
      if (along_row) begin
        x += dx;
        if (x < 0 || x >= gw) begin
          x = (dx > 0) ? 0 : gw - 1;
          y += dy;
        end
      end else begin
        y += dy;
        if (y < 0 || y >= gh) begin
          y = (dy > 0) ? 0 : gh - 1;
          x += dx;
        end
      end
    end
    if (!hit) return r;
    mark_col[c] = x;
    mark_row[c] = y;
    w = 0;
    h = 0;
    widen = 1'b1;
    heighten = 1'b1;
    while (widen || heighten) begin
      if (widen) begin
        w++;
        nx = x + w * dx;
        if (nx < 0 || nx >= gw) widen = 1'b0;
      end
      if (heighten) begin
        h++;
        ny = y + h * dy;
        if (ny < 0 || ny >= gh) heighten = 1'b0;
      end
      if (widen) begin
        for (i = 0; i < h; i++) begin
          if (!free_cells[y + dy * i][x + dx * w]) begin
            widen = 1'b0;
            break;
          end
        end
      end
      if (heighten) begin
        for (i = 0; i < w; i++) begin
          if (!free_cells[y + dy * h][x + dx * i]) begin
            heighten = 1'b0;
            break;
          end
        end
      end
      if (widen && heighten && !free_cells[y + dy * h][x + dx * w]) heighten = 1'b0;
      // The ratio test follows the growth, so the last step may overshoot.
      if (h > RATIO * w || w > RATIO * h) break;
    end
    rx = (dx > 0) ? x : x - w + 1;
    ry = (dy > 0) ? y : y - h + 1;
    for (iy = 0; iy < h; iy++)
      for (ix = 0; ix < w; ix++)
        free_cells[ry + iy][rx + ix] = 1'b0;
    r.found = 1'b1;
    r.x = rx[5:0];
    r.y = ry[5:0];
    r.w = w[6:0];
    r.h = h[6:0];
    return r;
  endfunction

  function automatic void apply_req(logic [IN_DATA_W-1:0] d);
    int c;
    case (d[1:0])
      REQ_LOAD: filled_cells[d[13:8]][d[7:2]] = d[14];
      REQ_START: begin
        free_cells = filled_cells;
        for (c = 0; c < 8; c++) begin
          mark_col[c] = (c >= 2 && c <= 5) ? used_dim(width_reg) - 1 : 0;
          mark_row[c] = (c >= 4) ? used_dim(height_reg) - 1 : 0;
        end
      end
      REQ_TAKE: expected_rects.insert(expected_rects.size(), take_rect(int'(d[17:15])));
      default: ;  // the unused request code is dropped by the block
    endcase
  endfunction

  // Stream driver: bursts of random length separated by random gaps. Every
  // accepted transfer updates the prediction before the next item goes out.
  int burst_left = 0;
  int gap_left   = 0;
  bit took;

  always @(posedge clk) begin
    took = s_axis_tvalid && s_axis_tready;
    if (took) apply_req(s_axis_tdata);
    if (!s_axis_tvalid || took) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        s_axis_tdata  <= pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver. The receiver cycles through windows of no
  // stalls, light stalls and heavy stalls, and once holds off for a long
  // stretch so that the output register fills and the input backs up.
  int  rx_cycle  = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;
  rect_t want;

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_rects.size() == 0) begin
        $error("result transfer with no rectangle expected: data %h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = expected_rects.pop_front();
        if (m_axis_tuser !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_axis_tuser);
          failed = 1'b1;
        end
        if (m_axis_tdata[5:0] !== want.x) begin
          $error("rect_x: expected %0d, got %0d", want.x, m_axis_tdata[5:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[11:6] !== want.y) begin
          $error("rect_y: expected %0d, got %0d", want.y, m_axis_tdata[11:6]);
          failed = 1'b1;
        end
        if (m_axis_tdata[18:12] !== want.w) begin
          $error("rect_w: expected %0d, got %0d", want.w, m_axis_tdata[18:12]);
          failed = 1'b1;
        end
        if (m_axis_tdata[25:19] !== want.h) begin
          $error("rect_h: expected %0d, got %0d", want.h, m_axis_tdata[25:19]);
          failed = 1'b1;
        end
      end
    end
    rx_cycle++;
    if (!held_once && results_seen >= 60) begin
      held_once = 1'b1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 700) % 3)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic queue_req(logic [1:0] kind, logic [5:0] cx, logic [5:0] cy,
                           logic fill, logic [2:0] corner);
    pending_reqs.insert(pending_reqs.size(), pack_req(kind, cx, cy, fill, corner));
    items_queued++;
  endtask

  // Wait until every queued request is accepted and every rectangle returned,
  // then give a start or load still in flight time to finish.
  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rects.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GRID_WIDTH) width_reg = val;
    else height_reg = val;
    cfg_valid <= 1'b0;
  endtask

  // One pass: load every cell of the grid in use at a random density, add a
  // few stray loads anywhere, start, then take (gw * gh) / 3 + extra_takes times.
  task automatic fill_and_cover(int gw, int gh, int extra_takes);
    int density, x, y, n;
    density = $urandom_range(20, 100);
    for (y = 0; y < gh; y++)
      for (x = 0; x < gw; x++)
        queue_req(REQ_LOAD, x[5:0], y[5:0], $urandom_range(1, 100) <= density,
                  3'($urandom_range(0, 7)));
    for (n = 0; n < 3; n++)
      queue_req(REQ_LOAD, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    if ($urandom_range(0, 9) == 0)
      queue_req(REQ_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    queue_req(REQ_START, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    for (n = 0; n < (gw * gh) / 3 + extra_takes; n++)
      queue_req(REQ_TAKE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
  endtask

  initial begin
    int c, gw, gh;
    logic [6:0] wv, hv;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the full grid: corner cells, a cleared cell, the unused
    // request code, then a take from each of the eight corners and one more.
    write_reg(CFG_GRID_WIDTH, 7'd127);
    write_reg(CFG_GRID_HEIGHT, 7'd64);
    queue_req(REQ_LOAD, 6'd0, 6'd0, 1'b1, 3'd7);
    queue_req(REQ_LOAD, 6'd63, 6'd63, 1'b1, 3'd0);
    queue_req(REQ_LOAD, 6'd63, 6'd0, 1'b1, 3'd0);
    queue_req(REQ_LOAD, 6'd0, 6'd63, 1'b1, 3'd0);
    queue_req(REQ_LOAD, 6'd0, 6'd63, 1'b0, 3'd0);
    queue_req(REQ_LOAD, 6'd1, 6'd0, 1'b1, 3'd0);
    queue_req(REQ_UNUSED, 6'd63, 6'd63, 1'b1, 3'd7);
    queue_req(REQ_START, 6'd0, 6'd0, 1'b0, 3'd0);
    for (c = 0; c < 8; c++) queue_req(REQ_TAKE, 6'd0, 6'd0, 1'b0, c[2:0]);
    queue_req(REQ_TAKE, 6'd0, 6'd0, 1'b0, 3'd0);
    drain();

    // A filled run of row 0 and of column 62 on the full grid, then takes from
    // corners two to seven after the grid shrinks so that their marks sit outside it.
    for (c = 0; c < 12; c++) queue_req(REQ_LOAD, c[5:0], 6'd0, 1'b1, 3'd0);
    for (c = 0; c < 4; c++) queue_req(REQ_LOAD, 6'd62, 6'(60 + c), 1'b1, 3'd0);
    queue_req(REQ_START, 6'd0, 6'd0, 1'b0, 3'd0);
    queue_req(REQ_TAKE, 6'd0, 6'd0, 1'b0, 3'd0);
    drain();
    write_reg(CFG_GRID_WIDTH, 7'd5);
    write_reg(CFG_GRID_HEIGHT, 7'd0);
    for (c = 2; c < 8; c++) queue_req(REQ_TAKE, 6'd0, 6'd0, 1'b0, c[2:0]);
    drain();

    // Random passes, mostly on small grids where the ratio limit bites.
    while (items_queued < ITEM_GOAL) begin
      case ($urandom_range(0, 19))
        0:       wv = 7'd0;
        1:       wv = 7'd1;
        default: wv = 7'($urandom_range(1, 10));
      endcase
      case ($urandom_range(0, 19))
        0:       hv = 7'd0;
        1:       hv = 7'd1;
        default: hv = 7'($urandom_range(1, 10));
      endcase
      write_reg(CFG_GRID_WIDTH, wv);
      write_reg(CFG_GRID_HEIGHT, hv);
      gw = used_dim(wv);
      gh = used_dim(hv);
      fill_and_cover(gw, gh, $urandom_range(2, 8));
      if ($urandom_range(0, 2) == 0) fill_and_cover(gw, gh, $urandom_range(1, 4));
      // The sender pauses until every rectangle is back before the grid size
      // changes again.
      drain();
    end
    drain();

    if (!failed) begin
      $display("** greedy_rectangle_cover: PASSED **");
    end else begin
      $display("** greedy_rectangle_cover: FAILED **");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("** greedy_rectangle_cover: FAILED **");
    $finish;
  end

endmodule
